/* design/segi_pkg.sv */
// ----------------------------------------------------------------------------
// segi_pkg
// Widths, result codes and saturation limits shared by the segment
// intersection unit and its channel interfaces.
// ----------------------------------------------------------------------------
package segi_pkg;

   localparam int CW    = 16;          // input coordinate
   localparam int DW    = CW + 1;      // coordinate difference
   localparam int PW    = 2 * DW;      // cross product / numerator, signed
   localparam int MW    = PW - 1;      // magnitude of normalized denominator
   localparam int LOW   = DW;          // split point of the wide multiplies
   localparam int PPW   = DW + LOW + 1;// partial product
   localparam int SW    = 51;          // p*den + d*num, signed
   localparam int MAGW  = SW - 1;      // its magnitude
   localparam int QF    = 8;           // fraction bits of the point
   localparam int AW    = MAGW + QF;   // scaled dividend magnitude
   localparam int QW    = 23;          // quotient bits, one per divider stage
   localparam int OW    = QW + 1;      // point coordinate
   localparam int NLANE = 3;           // x, y, z

   localparam logic [OW-1:0] PT_MAX = {1'b0, {QW{1'b1}}};
   localparam logic [OW-1:0] PT_MIN = {1'b1, {QW{1'b0}}};

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_UNBOUNDED = 2'd1,
      KIND_BOUNDED   = 2'd2
   } kind_type;

endpackage

/* design/segi_ifs.sv */
// ----------------------------------------------------------------------------
// segi_ifs
// Valid/ready channels of the segment intersection unit: request beat with
// two segments, response beat with kind and Q16.8 point.
// ----------------------------------------------------------------------------
interface segi_req_if;
   import segi_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] first_start_x;
   logic signed [CW-1:0] first_start_y;
   logic signed [CW-1:0] first_start_z;
   logic signed [CW-1:0] first_end_x;
   logic signed [CW-1:0] first_end_y;
   logic signed [CW-1:0] first_end_z;
   logic signed [CW-1:0] second_start_x;
   logic signed [CW-1:0] second_start_y;
   logic signed [CW-1:0] second_end_x;
   logic signed [CW-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_start_z,
             first_end_x, first_end_y, first_end_z,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );

   modport sink (
      input  valid, first_start_x, first_start_y, first_start_z,
             first_end_x, first_end_y, first_end_z,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

interface segi_rsp_if;
   import segi_pkg::*;

   logic                 valid;
   logic                 ready;
   kind_type             kind;
   logic signed [OW-1:0] point_x;
   logic signed [OW-1:0] point_y;
   logic signed [OW-1:0] point_z;

   modport source (
      output valid, kind, point_x, point_y, point_z,
      input  ready
   );

   modport sink (
      input  valid, kind, point_x, point_y, point_z,
      output ready
   );
endinterface

/* design/segment_intersection_unit.sv */
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Throughput: one beat per clock while responses are taken; 32 register
// stages, 23 of them a restoring divider (one quotient bit per stage) with
// a lane each for x, y and z sharing one denominator.
// A response not taken holds the whole pipe; bubbles are kept.
// Reset (synchronous) clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module segment_intersection_unit (
   input  logic       clock,
   input  logic       reset,
   segi_req_if.sink   req_bus,
   segi_rsp_if.source rsp_bus
);
   import segi_pkg::*;

   localparam int NFRONT = 8;
   localparam int NST    = NFRONT + QW + 1;

   typedef struct packed {
      logic signed [DW-1:0] ax, ay, az, bx, by, cx, cy;
      logic signed [CW-1:0] px, py, pz;
   } diff_type;

   typedef struct packed {
      logic signed [CW-1:0] p;
      logic signed [DW-1:0] d;
   } src_type;

   typedef struct packed {
      logic signed [PW-1:0] den_a, den_b, na_a, na_b, nb_a, nb_b;
      src_type [NLANE-1:0]  src;
   } prod_type;

   typedef struct packed {
      logic signed [PW-1:0] den, na, nb;
      src_type [NLANE-1:0]  src;
   } cross_type;

   typedef struct packed {
      logic                 zero;
      logic [MW-1:0]        den;
      logic signed [PW-1:0] na, nb;
      src_type [NLANE-1:0]  src;
   } norm_type;

   typedef struct packed {
      logic signed [PPW-1:0] pp0, pp1, pp2, pp3;
   } pp_type;

   typedef struct packed {
      kind_type           kind;
      logic [MW-1:0]      den;
      pp_type [NLANE-1:0] pp;
   } part_type;

   typedef struct packed {
      kind_type                  kind;
      logic [MW-1:0]             den;
      logic [NLANE-1:0][SW-1:0]  xs;
   } sum_type;

   typedef struct packed {
      kind_type                   kind;
      logic [MW-1:0]              den;
      logic [NLANE-1:0]           neg;
      logic [NLANE-1:0][MAGW-1:0] mag;
   } mag_type;

   typedef struct packed {
      logic [MW-1:0] rem;
      logic [QW-1:0] sq;
      logic          neg;
      logic          ovf;
   } div_lane_type;

   typedef struct packed {
      kind_type                 kind;
      logic [MW-1:0]            den;
      div_lane_type [NLANE-1:0] lane;
   } div_stage_type;

   typedef struct packed {
      kind_type                kind;
      logic [NLANE-1:0][OW-1:0] pt;
   } out_type;

   logic                adv;
   logic [NST-1:0]      vld_ff, vld_in;
   diff_type            s1_ff, s1_in;
   prod_type            s2_ff, s2_in;
   cross_type           s3_ff, s3_in;
   norm_type            s4_ff, s4_in;
   part_type            s5_ff, s5_in;
   sum_type             s6_ff, s6_in;
   mag_type             s7_ff, s7_in;
   div_stage_type       div_ff [QW+1];
   div_stage_type       div_in [QW+1];
   out_type             out_ff, out_in;

   assign adv           = !vld_ff[NST-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign vld_in        = {vld_ff[NST-2:0], req_bus.valid};

   // differences
   always_comb begin
      s1_in.ax = DW'(req_bus.first_end_x) - DW'(req_bus.first_start_x);
      s1_in.ay = DW'(req_bus.first_end_y) - DW'(req_bus.first_start_y);
      s1_in.az = DW'(req_bus.first_end_z) - DW'(req_bus.first_start_z);
      s1_in.bx = DW'(req_bus.second_start_x) - DW'(req_bus.second_end_x);
      s1_in.by = DW'(req_bus.second_start_y) - DW'(req_bus.second_end_y);
      s1_in.cx = DW'(req_bus.first_start_x) - DW'(req_bus.second_start_x);
      s1_in.cy = DW'(req_bus.first_start_y) - DW'(req_bus.second_start_y);
      s1_in.px = req_bus.first_start_x;
      s1_in.py = req_bus.first_start_y;
      s1_in.pz = req_bus.first_start_z;
   end

   // cross products
   always_comb begin
      s2_in.den_a  = $signed(s1_ff.ay) * $signed(s1_ff.bx);
      s2_in.den_b  = $signed(s1_ff.ax) * $signed(s1_ff.by);
      s2_in.na_a   = $signed(s1_ff.by) * $signed(s1_ff.cx);
      s2_in.na_b   = $signed(s1_ff.bx) * $signed(s1_ff.cy);
      s2_in.nb_a   = $signed(s1_ff.ax) * $signed(s1_ff.cy);
      s2_in.nb_b   = $signed(s1_ff.ay) * $signed(s1_ff.cx);
      s2_in.src[0] = {s1_ff.px, s1_ff.ax};
      s2_in.src[1] = {s1_ff.py, s1_ff.ay};
      s2_in.src[2] = {s1_ff.pz, s1_ff.az};
   end

   always_comb begin
      s3_in.den = $signed(s2_ff.den_a) - $signed(s2_ff.den_b);
      s3_in.na  = $signed(s2_ff.na_a) - $signed(s2_ff.na_b);
      s3_in.nb  = $signed(s2_ff.nb_a) - $signed(s2_ff.nb_b);
      s3_in.src = s2_ff.src;
   end

   // make the denominator positive
   always_comb begin
      logic [PW-1:0] d_abs;
      d_abs      = s3_ff.den[PW-1] ? (PW'(0) - s3_ff.den) : s3_ff.den;
      s4_in.zero = (s3_ff.den == '0);
      s4_in.den  = d_abs[MW-1:0];
      s4_in.na   = s3_ff.den[PW-1] ? (PW'(0) - s3_ff.na) : s3_ff.na;
      s4_in.nb   = s3_ff.den[PW-1] ? (PW'(0) - s3_ff.nb) : s3_ff.nb;
      s4_in.src  = s3_ff.src;
   end

   // range test and split multiplies for p*den + d*na
   always_comb begin
      logic na_in, nb_in;
      na_in = !s4_ff.na[PW-1] && (s4_ff.na[MW-1:0] <= s4_ff.den);
      nb_in = !s4_ff.nb[PW-1] && (s4_ff.nb[MW-1:0] <= s4_ff.den);
      if (s4_ff.zero) begin
         s5_in.kind = KIND_NONE;
      end else if (na_in && nb_in) begin
         s5_in.kind = KIND_BOUNDED;
      end else begin
         s5_in.kind = KIND_UNBOUNDED;
      end
      s5_in.den = s4_ff.den;
      for (int l = 0; l < NLANE; l++) begin
         s5_in.pp[l].pp0 = $signed(s4_ff.src[l].p) * $signed({1'b0, s4_ff.den[LOW-1:0]});
         s5_in.pp[l].pp1 = $signed(s4_ff.src[l].p) * $signed({1'b0, s4_ff.den[MW-1:LOW]});
         s5_in.pp[l].pp2 = $signed(s4_ff.src[l].d) * $signed({1'b0, s4_ff.na[LOW-1:0]});
         s5_in.pp[l].pp3 = $signed(s4_ff.src[l].d) * $signed(s4_ff.na[PW-1:LOW]);
      end
   end

   always_comb begin
      s6_in.kind = s5_ff.kind;
      s6_in.den  = s5_ff.den;
      for (int l = 0; l < NLANE; l++) begin
         s6_in.xs[l] = SW'($signed(s5_ff.pp[l].pp0))
                     + (SW'($signed(s5_ff.pp[l].pp1)) <<< LOW)
                     + SW'($signed(s5_ff.pp[l].pp2))
                     + (SW'($signed(s5_ff.pp[l].pp3)) <<< LOW);
      end
   end

   always_comb begin
      logic [SW-1:0] x_abs;
      s7_in.kind = s6_ff.kind;
      s7_in.den  = s6_ff.den;
      for (int l = 0; l < NLANE; l++) begin
         x_abs          = s6_ff.xs[l][SW-1] ? (SW'(0) - s6_ff.xs[l]) : s6_ff.xs[l];
         s7_in.neg[l]   = s6_ff.xs[l][SW-1];
         s7_in.mag[l]   = x_abs[MAGW-1:0];
      end
   end

   // overflow check, divider load, then restoring divider, one quotient bit per stage
   always_comb begin
      logic [AW-1:0] dvd;
      logic [MW:0]   trial;
      logic          ge;
      div_in[0].kind = s7_ff.kind;
      div_in[0].den  = s7_ff.den;
      for (int l = 0; l < NLANE; l++) begin
         dvd                    = {s7_ff.mag[l], QF'(0)};
         div_in[0].lane[l].ovf  = dvd >= AW'({s7_ff.den, QW'(0)});
         div_in[0].lane[l].neg  = s7_ff.neg[l];
         div_in[0].lane[l].rem  = dvd[QW +: MW];
         div_in[0].lane[l].sq   = dvd[QW-1:0];
      end
      div_in[1:QW] = div_ff[0:QW-1];
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < NLANE; l++) begin
            trial = {div_ff[k].lane[l].rem, div_ff[k].lane[l].sq[QW-1]};
            ge    = trial >= {1'b0, div_ff[k].den};
            div_in[k+1].lane[l].rem = ge ? MW'(trial - {1'b0, div_ff[k].den})
                                         : trial[MW-1:0];
            div_in[k+1].lane[l].sq  = {div_ff[k].lane[l].sq[QW-2:0], ge};
         end
      end
   end

   // sign, saturation, parallel case
   always_comb begin
      out_in.kind = div_ff[QW].kind;
      for (int l = 0; l < NLANE; l++) begin
         if (div_ff[QW].kind == KIND_NONE) begin
            out_in.pt[l] = '0;
         end else if (div_ff[QW].lane[l].ovf) begin
            out_in.pt[l] = div_ff[QW].lane[l].neg ? PT_MIN : PT_MAX;
         end else if (div_ff[QW].lane[l].neg) begin
            out_in.pt[l] = OW'(0) - {1'b0, div_ff[QW].lane[l].sq};
         end else begin
            out_in.pt[l] = {1'b0, div_ff[QW].lane[l].sq};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         div_ff <= div_in;
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid   = vld_ff[NST-1];
   assign rsp_bus.kind    = out_ff.kind;
   assign rsp_bus.point_x = $signed(out_ff.pt[0]);
   assign rsp_bus.point_y = $signed(out_ff.pt[1]);
   assign rsp_bus.point_z = $signed(out_ff.pt[2]);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe moved while output beat stalled");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-2] && (div_ff[QW].kind != KIND_NONE) && !div_ff[QW].lane[0].ovf
      |-> div_ff[QW].lane[0].rem < div_ff[QW].den)
      else $error("divider remainder not below denominator");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == KIND_NONE)
      |-> (rsp_bus.point_x == '0) && (rsp_bus.point_y == '0) && (rsp_bus.point_z == '0))
      else $error("parallel result with nonzero point");

   a_bounded_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == KIND_BOUNDED)
      |-> (rsp_bus.point_x != PT_MAX) && (rsp_bus.point_y != PT_MAX)
          && (rsp_bus.point_z != PT_MAX))
      else $error("point on both segments hit saturation");

endmodule

/* verif/tb_segment_intersection_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_unit
// Streams segment pairs through the intersection unit: first a table of
// directed pairs, some with the answer written in, then randomly shaped
// pairs. Other results are checked against an in-bench integer model of the
// crossing test and the Q16.8 point. The request side offers beats in bursts
// with gaps, and the response side stalls on its own pattern. Twice it holds
// off long enough for the pipe to fill and stop taking requests.
// ----------------------------------------------------------------------------
module tb_segment_intersection_unit;
   import segi_pkg::*;

   localparam int     NUM_RANDOM  = 1900;
   localparam int     DRAIN_WAIT  = 64;
   localparam int     HOLD_CYCLES = 160;
   localparam int     CYCLE_LIMIT = 400000;
   localparam longint SAT_HI      = (longint'(1) <<< (OW - 1)) - 1;
   localparam longint SAT_LO      = -(longint'(1) <<< (OW - 1));

   typedef struct packed {
      logic signed [CW-1:0] first_start_x;
      logic signed [CW-1:0] first_start_y;
      logic signed [CW-1:0] first_start_z;
      logic signed [CW-1:0] first_end_x;
      logic signed [CW-1:0] first_end_y;
      logic signed [CW-1:0] first_end_z;
      logic signed [CW-1:0] second_start_x;
      logic signed [CW-1:0] second_start_y;
      logic signed [CW-1:0] second_end_x;
      logic signed [CW-1:0] second_end_y;
   } seg_pair_type;

   typedef struct packed {
      kind_type             kind;
      logic signed [OW-1:0] x;
      logic signed [OW-1:0] y;
      logic signed [OW-1:0] z;
   } crossing_type;

   typedef struct packed {
      seg_pair_type pair;
      logic         typed;
      crossing_type want;
   } dir_row_type;

   localparam int NDIR = 19;

   // pair: fs.xyz, fe.xyz, ss.xy, se.xy ; typed ; kind, x, y, z
   localparam dir_row_type DIRECTED [NDIR] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{KIND_NONE, 0, 0, 0}},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
        1'b1, '{KIND_NONE, 0, 0, 0}},
      '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768}, 1'b1, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 2, 2, 4, 0, 2, 2, 0}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 1, 1, 0, 0, 4, 4, 0}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 4, 0, 0, 0, -2, 0, 2}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 7, 4, 0, 9, 4, -2, 4, 2}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 1, 0, 0, 0, 2, 32767, 1}, 1'b1,
        '{KIND_UNBOUNDED, PT_MAX, 0, 0}},
      '{'{0, 0, 0, 1, 0, 0, 0, 2, -32767, 1}, 1'b1,
        '{KIND_UNBOUNDED, PT_MIN, 0, 0}},
      '{'{0, 0, 5, 4, 4, 9, 1, 1, 3, 3}, 1'b1, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 4, 0, 0, 0, 1, 4, 1}, 1'b1, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 4, 4, 4, 2, 2, 2, 2}, 1'b1, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, 4, 0, 0, 2, 1, 2, 3}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{4, 0, 0, 8, 0, 0, 2, -1, 2, 1}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{-32768, 0, 0, 32767, 0, 0, 0, -32768, 0, 32767}, 1'b1,
        '{KIND_BOUNDED, 0, 0, 0}},
      '{'{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767,
          -32768}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768,
          -32768}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{0, 0, 0, -3, 0, -7, -1, 1, -2, -2}, 1'b0, '{KIND_NONE, 0, 0, 0}},
      '{'{1, 2, 3, -5, 7, -11, 13, -17, 19, -23}, 1'b0, '{KIND_NONE, 0, 0, 0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   segi_req_if req_bus();
   segi_rsp_if rsp_bus();

   segment_intersection_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   crossing_type awaited_crossings[$];
   crossing_type got_point;
   crossing_type want_point;
   seg_pair_type taken_pair;
   logic         offer_typed = 1'b0;
   crossing_type offer_expect = '0;
   int           beats_in = 0;
   int           mismatches = 0;
   int           cycles = 0;
   int           burst_left = 0;
   int           next_holdoff = 300;

   // Q16.8 coordinate of base + step*num/den, truncated toward zero, saturated
   function automatic logic signed [OW-1:0] scale_point(longint base, longint step,
                                                          longint num, longint den);
      longint v;
      v = (base * den + step * num) * 256 / den;
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      return v[OW-1:0];
   endfunction

   function automatic crossing_type intersect_segments(seg_pair_type p);
      crossing_type r;
      longint ax, ay, az, bx, by, cx, cy, den, num_a, num_b;
      ax = longint'(p.first_end_x) - longint'(p.first_start_x);
      ay = longint'(p.first_end_y) - longint'(p.first_start_y);
      az = longint'(p.first_end_z) - longint'(p.first_start_z);
      bx = longint'(p.second_start_x) - longint'(p.second_end_x);
      by = longint'(p.second_start_y) - longint'(p.second_end_y);
      cx = longint'(p.first_start_x) - longint'(p.second_start_x);
      cy = longint'(p.first_start_y) - longint'(p.second_start_y);
      den   = ay * bx - ax * by;
      num_a = by * cx - bx * cy;
      num_b = ax * cy - ay * cx;
      r = '0;
      r.kind = KIND_NONE;
      if (den == 0) return r;
      if (den < 0) begin
         den   = -den;
         num_a = -num_a;
         num_b = -num_b;
      end
      r.kind = (num_a >= 0 && num_a <= den && num_b >= 0 && num_b <= den) ?
               KIND_BOUNDED : KIND_UNBOUNDED;
      r.x = scale_point(longint'(p.first_start_x), ax, num_a, den);
      r.y = scale_point(longint'(p.first_start_y), ay, num_a, den);
      r.z = scale_point(longint'(p.first_start_z), az, num_a, den);
      return r;
   endfunction

   function automatic logic signed [CW-1:0] near(int span);
      int v;
      v = $urandom_range(0, 2 * span);
      v = v - span;
      return CW'(v);
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      int           flavor;
      int           span;
      logic signed [CW-1:0] ox, oy;
      flavor = $urandom_range(0, 9);
      span = (flavor == 9) ? 4096 : 64;
      p.first_start_x  = near(span);
      p.first_start_y  = near(span);
      p.first_start_z  = CW'($urandom);
      p.first_end_x    = near(span);
      p.first_end_y    = near(span);
      p.first_end_z    = CW'($urandom);
      p.second_start_x = near(span);
      p.second_start_y = near(span);
      p.second_end_x   = near(span);
      p.second_end_y   = near(span);
      case (flavor)
         0, 1, 2: p = seg_pair_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         6: begin
            ox = near(span);
            oy = near(span);
            p.second_start_x = p.first_start_x + ox;
            p.second_start_y = p.first_start_y + oy;
            p.second_end_x   = p.first_end_x + ox;
            p.second_end_y   = p.first_end_y + oy;
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               p.second_start_x = p.first_end_x;
               p.second_start_y = p.first_end_y;
            end else begin
               p.second_end_x = p.first_start_x;
               p.second_end_y = p.first_start_y;
            end
         end
         8: begin
            p.first_start_x  = CW'(-int'($urandom_range(1, 32768)));
            p.first_start_y  = CW'(-int'($urandom_range(0, 32768)));
            p.first_end_x    = CW'($urandom_range(1, 32767));
            p.first_end_y    = CW'($urandom_range(0, 32767));
            p.second_start_x = CW'(-int'($urandom_range(0, 32768)));
            p.second_start_y = CW'($urandom_range(1, 32767));
            p.second_end_x   = CW'($urandom_range(0, 32767));
            p.second_end_y   = CW'(-int'($urandom_range(1, 32768)));
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic offer_pair(input seg_pair_type p, input logic typed,
                             input crossing_type want);
      int gap;
      req_bus.valid          <= 1'b1;
      req_bus.first_start_x  <= p.first_start_x;
      req_bus.first_start_y  <= p.first_start_y;
      req_bus.first_start_z  <= p.first_start_z;
      req_bus.first_end_x    <= p.first_end_x;
      req_bus.first_end_y    <= p.first_end_y;
      req_bus.first_end_z    <= p.first_end_z;
      req_bus.second_start_x <= p.second_start_x;
      req_bus.second_start_y <= p.second_start_y;
      req_bus.second_end_x   <= p.second_end_x;
      req_bus.second_end_y   <= p.second_end_y;
      offer_typed            <= typed;
      offer_expect           <= want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) :
                                                    $urandom_range(0, 20);
      end
   endtask

   // scoreboard: expectation pushed on request beat, checked on response beat
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_segment_intersection_unit: FAIL");
         $finish;
      end
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken_pair = '{req_bus.first_start_x, req_bus.first_start_y,
                           req_bus.first_start_z, req_bus.first_end_x,
                           req_bus.first_end_y, req_bus.first_end_z,
                           req_bus.second_start_x, req_bus.second_start_y,
                           req_bus.second_end_x, req_bus.second_end_y};
            awaited_crossings.push_back(offer_typed ? offer_expect :
                                        intersect_segments(taken_pair));
            beats_in++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_point = '{rsp_bus.kind, rsp_bus.point_x, rsp_bus.point_y,
                          rsp_bus.point_z};
            if (awaited_crossings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp beat: kind %0d point %0d %0d %0d",
                           got_point.kind, got_point.x, got_point.y, got_point.z);
            end else begin
               want_point = awaited_crossings.pop_front();
               if (got_point.kind !== want_point.kind || got_point.x !== want_point.x ||
                   got_point.y !== want_point.y || got_point.z !== want_point.z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want_point.kind, want_point.x, want_point.y, want_point.z,
                              got_point.kind, got_point.x, got_point.y, got_point.z);
               end
            end
         end
      end
   end

   // response side: random stall modes, plus long hold-offs to back up the pipe
   initial begin
      int mode;
      int run;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (beats_in >= next_holdoff) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            next_holdoff = (next_holdoff < 1200) ? 1200 : 32'h7fffffff;
         end
         mode = $urandom_range(0, 3);
         run = $urandom_range(8, 64);
         repeat (run) begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= $urandom_range(0, 1);
               2:       rsp_bus.ready <= (cycles % 4 != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      req_bus.valid          <= 1'b0;
      req_bus.first_start_x  <= '0;
      req_bus.first_start_y  <= '0;
      req_bus.first_start_z  <= '0;
      req_bus.first_end_x    <= '0;
      req_bus.first_end_y    <= '0;
      req_bus.first_end_z    <= '0;
      req_bus.second_start_x <= '0;
      req_bus.second_start_y <= '0;
      req_bus.second_end_x   <= '0;
      req_bus.second_end_y   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NDIR; i++)
         offer_pair(DIRECTED[i].pair, DIRECTED[i].typed, DIRECTED[i].want);
      for (int i = 0; i < NUM_RANDOM; i++)
         offer_pair(random_pair(), 1'b0, '0);
      req_bus.valid <= 1'b0;

      while (awaited_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("tb_segment_intersection_unit: PASS");
      else
         $display("tb_segment_intersection_unit: FAIL");
      $finish;
   end

endmodule
